// ----- design/abnal_pkg.sv -----
// ----------------------------------------------------------------------------
// abnal_pkg
// Shared widths, defaults and result codes for the Annex B to
// length-prefixed NAL converter.
// ----------------------------------------------------------------------------
package abnal_pkg;

   // Payload widths of the two channels
   localparam int unsigned BYTE_W      = 8;
   localparam int unsigned OUT_LEN_W   = 24;

   // Default width of the NAL length counter
   localparam int unsigned LENGTH_BITS_DEFAULT = 24;

   // Result kinds
   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_LENGTH  = 1'b1;

endpackage

// ----- design/abnal_req_if.sv -----
// ----------------------------------------------------------------------------
// abnal_req_if
// Byte channel into the converter: one Annex B byte per beat.
// ----------------------------------------------------------------------------
interface abnal_req_if;
   logic                           valid;
   logic                           ready;
   logic [abnal_pkg::BYTE_W-1:0]   byte_in;
   logic                           end_of_packet;

   modport source (output valid, output byte_in, output end_of_packet, input ready);
   modport sink   (input valid, input byte_in, input end_of_packet, output ready);
endinterface

// ----- design/abnal_rsp_if.sv -----
// ----------------------------------------------------------------------------
// abnal_rsp_if
// Result channel out of the converter: a payload byte or a NAL length per beat.
// ----------------------------------------------------------------------------
interface abnal_rsp_if;
   logic                              valid;
   logic                              ready;
   logic                              kind;
   logic [abnal_pkg::BYTE_W-1:0]      data_byte;
   logic                              first_of_nal;
   logic [abnal_pkg::OUT_LEN_W-1:0]   nal_length;
   logic                              packet_done;
   logic                              last_of_step;

   modport source (output valid, output kind, output data_byte, output first_of_nal,
                   output nal_length, output packet_done, output last_of_step,
                   input ready);
   modport sink   (input valid, input kind, input data_byte, input first_of_nal,
                   input nal_length, input packet_done, input last_of_step,
                   output ready);
endinterface

// ----- design/annexb_to_length_prefixed_nal.sv -----
// ----------------------------------------------------------------------------
// annexb_to_length_prefixed_nal
// Annex B byte stream to length-prefixed NAL converter.
// ----------------------------------------------------------------------------
// Each accepted byte is decoded in the cycle it arrives and turns into zero to
// four result beats, held in one result register and played out one beat per
// cycle while the receiver is ready. A byte that gives no result or one result
// does not hold up the next byte, so plain payload streams at one byte per
// cycle when the result side does not stall; a byte that releases held zeros
// or closes a NAL holds off the next byte until its result beats (up to four)
// have drained from the result register. A new byte is taken in the same
// cycle the last beat of the previous one is taken. A length beat follows the
// last payload byte of every non-empty NAL and is meant to be back-filled as
// a 4-byte big-endian prefix; lengths saturate at 2^LENGTH_BITS-1 and are
// reported in the low 24 bits. Bytes before the first start code of a packet
// are dropped, and all state clears after the byte that carries end_of_packet.
// ----------------------------------------------------------------------------
module annexb_to_length_prefixed_nal #(
   parameter int unsigned LENGTH_BITS = abnal_pkg::LENGTH_BITS_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   abnal_req_if.sink    req_ch,
   abnal_rsp_if.source  rsp_ch
);
   import abnal_pkg::*;

   localparam logic SCAN_SEARCH = 1'b0;
   localparam logic SCAN_NAL    = 1'b1;
   localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;

   // Scanner state
   logic                   phase_ff, phase_in;
   logic [1:0]             pend_ff, pend_in;
   logic [LENGTH_BITS-1:0] count_ff, count_in;
   logic                   first_ff, first_in;

   // Result register: npay payload beats, then an optional length beat
   logic [1:0]             npay_ff, npay_in;
   logic                   has_b_ff, has_b_in;
   logic [BYTE_W-1:0]      byte_ff;
   logic                   nal_first_ff;
   logic                   has_close_in;
   logic [LENGTH_BITS-1:0] len_ff, len_in;
   logic                   eop_ff;
   logic [2:0]             total_ff, total_in;
   logic [1:0]             idx_ff;

   logic                   is_zero, is_one, start_code;
   logic [1:0]             pend_plus;
   logic [LENGTH_BITS:0]   len_sum;
   logic [LENGTH_BITS-1:0] sat_len;
   logic                   req_fire, rsp_fire, rsp_last, out_close;
   logic [LENGTH_BITS+OUT_LEN_W-1:0] len_ext;

   // Decode the incoming byte
   assign is_zero    = (req_ch.byte_in == '0);
   assign is_one     = (req_ch.byte_in == BYTE_W'(1));
   assign start_code = (phase_ff == SCAN_NAL) && pend_ff[1] && (is_zero || is_one);
   assign pend_plus  = pend_ff + 2'd1;

   // Count payload beats released by this byte
   always_comb begin
      npay_in  = 2'd0;
      has_b_in = 1'b0;
      if ((phase_ff == SCAN_NAL) && !start_code) begin
         if (is_zero) begin
            npay_in = req_ch.end_of_packet ? pend_plus : 2'd0;
         end else begin
            npay_in  = pend_plus;
            has_b_in = 1'b1;
         end
      end
   end

   // Saturating NAL length after this byte's payload
   assign len_sum = {1'b0, count_ff} + {{(LENGTH_BITS-1){1'b0}}, npay_in};
   assign sat_len = len_sum[LENGTH_BITS] ? LEN_MAX : len_sum[LENGTH_BITS-1:0];

   // Close the NAL on a start code, or at end of packet inside a NAL
   always_comb begin
      if (start_code) begin
         len_in       = count_ff;
         has_close_in = (count_ff != '0);
      end else begin
         len_in       = sat_len;
         has_close_in = req_ch.end_of_packet && (phase_ff == SCAN_NAL) && (sat_len != '0);
      end
      total_in = {1'b0, npay_in} + {2'b00, has_close_in};
   end

   // Advance scanner state
   always_comb begin
      phase_in = phase_ff;
      pend_in  = pend_ff;
      count_in = count_ff;
      first_in = first_ff;
      if (req_ch.end_of_packet) begin
         phase_in = SCAN_SEARCH;
         pend_in  = 2'd0;
         count_in = '0;
         first_in = 1'b0;
      end else if (phase_ff == SCAN_SEARCH) begin
         if (is_one && pend_ff[1]) begin
            phase_in = SCAN_NAL;
            pend_in  = 2'd0;
            first_in = 1'b1;
            count_in = '0;
         end else if (is_zero) begin
            pend_in = (pend_ff == 2'd3) ? 2'd3 : pend_plus;
         end else begin
            pend_in = 2'd0;
         end
      end else if (start_code) begin
         count_in = '0;
         if (is_zero) begin
            phase_in = SCAN_SEARCH;
            pend_in  = 2'd3;
            first_in = 1'b0;
         end else begin
            pend_in  = 2'd0;
            first_in = 1'b1;
         end
      end else if (is_zero) begin
         pend_in = pend_plus;
      end else begin
         pend_in  = 2'd0;
         count_in = sat_len;
         first_in = 1'b0;
      end
   end

   // Handshake: take a new byte when the result register is empty or its last beat is taken
   assign rsp_last     = ({1'b0, idx_ff} + 3'd1) == total_ff;
   assign rsp_ch.valid = (total_ff != 3'd0);
   assign rsp_fire     = rsp_ch.valid && rsp_ch.ready;
   assign req_ch.ready = (total_ff == 3'd0) || (rsp_ch.ready && rsp_last);
   assign req_fire     = req_ch.valid && req_ch.ready;

   // Select the current beat
   assign out_close  = (idx_ff == npay_ff);
   assign len_ext    = {{OUT_LEN_W{1'b0}}, len_ff};
   assign rsp_ch.kind         = out_close ? KIND_LENGTH : KIND_PAYLOAD;
   assign rsp_ch.data_byte    = (!out_close && has_b_ff && (idx_ff + 2'd1 == npay_ff))
                                ? byte_ff : '0;
   assign rsp_ch.first_of_nal = !out_close && (idx_ff == 2'd0) && nal_first_ff;
   assign rsp_ch.nal_length   = out_close ? len_ext[OUT_LEN_W-1:0] : '0;
   assign rsp_ch.packet_done  = rsp_last && eop_ff;
   assign rsp_ch.last_of_step = rsp_last;

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= SCAN_SEARCH;
         pend_ff  <= 2'd0;
         count_ff <= '0;
         first_ff <= 1'b0;
         total_ff <= 3'd0;
         idx_ff   <= 2'd0;
      end else begin
         if (req_fire) begin
            phase_ff <= phase_in;
            pend_ff  <= pend_in;
            count_ff <= count_in;
            first_ff <= first_in;
            total_ff <= total_in;
            idx_ff   <= 2'd0;
         end else if (rsp_fire) begin
            if (rsp_last) begin
               total_ff <= 3'd0;
            end else begin
               idx_ff <= idx_ff + 2'd1;
            end
         end
      end
   end

   // Result payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         npay_ff      <= npay_in;
         has_b_ff     <= has_b_in;
         byte_ff      <= req_ch.byte_in;
         nal_first_ff <= first_ff;
         len_ff       <= len_in;
         eop_ff       <= req_ch.end_of_packet;
      end
   end

endmodule

// ----- tb/annexb_to_length_prefixed_nal_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// annexb_to_length_prefixed_nal_test
// Self-checking bench for the Annex B to length-prefixed NAL converter.
// ----------------------------------------------------------------------------
// A byte driver plays out a queue of Annex B packets with random gaps. A
// monitor predicts the payload and length beats for every accepted byte and
// checks every result beat against the oldest prediction. Directed packets
// cover start codes of both sizes, released zeros, closing zeros, empty NALs,
// leading garbage and end of packet inside a NAL. Random packets follow,
// mostly well formed with random content. The result side stalls at random,
// holds off once for a long stretch, and the sender drains now and then.
// ----------------------------------------------------------------------------
module annexb_to_length_prefixed_nal_test;
   import abnal_pkg::*;

   typedef struct packed {
      logic                 kind;
      logic [BYTE_W-1:0]    data_byte;
      logic                 first_of_nal;
      logic [OUT_LEN_W-1:0] nal_length;
      logic                 packet_done;
      logic                 last_of_step;
   } nal_beat_type;

   typedef struct {
      logic [BYTE_W-1:0] value;
      logic              eop;
      bit                drain;
   } stream_byte_type;

   localparam int RANDOM_BYTES   = 420;
   localparam int LONG_HOLD      = 100;
   localparam int HOLD_AFTER     = 120;
   localparam int TAIL_CYCLES    = 16;
   localparam int REPORT_LIMIT   = 10;

   logic clock;
   logic reset = 1'b1;

   abnal_req_if req_bus ();
   abnal_rsp_if rsp_bus ();

   annexb_to_length_prefixed_nal uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   // Stimulus and scoreboard storage
   stream_byte_type   annexb_bytes[$];
   logic [BYTE_W-1:0] pkt_bytes[$];
   nal_beat_type      expected_beats[$];
   nal_beat_type      step_beats[$];
   int                total_items;
   int                bytes_taken;
   int                beats_checked;
   int                mismatch_count;
   bit                results_idle;
   bit                calm;
   int                cycle_count;

   // Predicted converter state
   bit                                   in_nal;
   logic [1:0]                           zero_run;
   logic [LENGTH_BITS_DEFAULT-1:0]       nal_bytes;
   bit                                   open_pending;

   // ------------------------------------------------------------------------
   // Converter predictor
   // ------------------------------------------------------------------------
   task automatic clear_state();
      in_nal       = 1'b0;
      zero_run     = '0;
      nal_bytes    = '0;
      open_pending = 1'b0;
   endtask

   task automatic emit_payload(input logic [BYTE_W-1:0] value);
      nal_beat_type beat;
      beat              = '0;
      beat.kind         = KIND_PAYLOAD;
      beat.data_byte    = value;
      beat.first_of_nal = open_pending;
      step_beats        = {step_beats, beat};
      open_pending = 1'b0;
      if (nal_bytes != '1) nal_bytes = nal_bytes + 1'b1;
   endtask

   // Give out the held zeros as payload
   task automatic release_zeros();
      int i;
      for (i = 0; i < zero_run && i < 2; i++) emit_payload('0);
   endtask

   // Close the open NAL; an empty one gives no length beat
   task automatic close_nal();
      nal_beat_type beat;
      if (nal_bytes != '0) begin
         beat            = '0;
         beat.kind       = KIND_LENGTH;
         beat.nal_length = OUT_LEN_W'(nal_bytes);
         step_beats      = {step_beats, beat};
      end
      nal_bytes = '0;
   endtask

   task automatic predict_byte(input logic [BYTE_W-1:0] value, input logic eop);
      nal_beat_type beat;
      step_beats.delete();
      if (!in_nal) begin
         if (value == 8'h01 && zero_run >= 2) begin
            in_nal       = 1'b1;
            zero_run     = '0;
            open_pending = 1'b1;
            nal_bytes    = '0;
         end else if (value == 8'h00) begin
            if (zero_run < 3) zero_run = zero_run + 1'b1;
         end else begin
            zero_run = '0;
         end
      end else begin
         if (value == 8'h00 && zero_run >= 2) begin
            // three zeros end the NAL and restart the search
            close_nal();
            in_nal       = 1'b0;
            zero_run     = 2'd3;
            open_pending = 1'b0;
         end else if (value == 8'h01 && zero_run >= 2) begin
            close_nal();
            zero_run     = '0;
            open_pending = 1'b1;
         end else if (value == 8'h00) begin
            zero_run = zero_run + 1'b1;
         end else begin
            release_zeros();
            zero_run = '0;
            emit_payload(value);
         end
      end
      if (eop) begin
         if (in_nal) begin
            release_zeros();
            close_nal();
         end
         clear_state();
      end
      // Flag the final beat of this byte
      if (step_beats.size() > 0) begin
         beat              = step_beats.pop_back();
         beat.last_of_step = 1'b1;
         beat.packet_done  = eop;
         step_beats        = {step_beats, beat};
      end
      expected_beats = {expected_beats, step_beats};
   endtask

   task automatic flag_error(input string msg);
      if (mismatch_count < REPORT_LIMIT) $display("%0t: %s", $realtime, msg);
      mismatch_count++;
   endtask

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------
   function automatic logic [BYTE_W-1:0] pick_byte();
      int roll;
      roll = $urandom_range(0, 9);
      if (roll < 3) return 8'h00;
      if (roll == 3) return 8'h01;
      if (roll == 4) return 8'h03;
      return BYTE_W'($urandom_range(0, 255));
   endfunction

   // Move the packet under construction onto the byte queue
   task automatic commit_packet(input bit drain);
      stream_byte_type item;
      foreach (pkt_bytes[i]) begin
         item.value   = pkt_bytes[i];
         item.eop     = (i == pkt_bytes.size() - 1);
         item.drain   = drain && (i == 0);
         annexb_bytes = {annexb_bytes, item};
      end
      pkt_bytes.delete();
   endtask

   // ------------------------------------------------------------------------
   // Clock, idle phases and watchdog
   // ------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count[5:0] == 6'd0) calm <= ($urandom_range(0, 3) == 0);
   end

   initial begin
      #2_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Byte driver: advance on each accepted beat, idle between items
   // ------------------------------------------------------------------------
   int gap_left;

   always @(posedge clock) begin : byte_driver
      stream_byte_type next_item;
      if (reset) begin
         req_bus.valid         <= 1'b0;
         req_bus.byte_in       <= '0;
         req_bus.end_of_packet <= 1'b0;
         gap_left              <= 0;
      end else if (!req_bus.valid || req_bus.ready) begin
         if (gap_left != 0) begin
            req_bus.valid <= 1'b0;
            gap_left      <= gap_left - 1;
         end else if (annexb_bytes.size() > 0 &&
                      (!annexb_bytes[0].drain || (results_idle && !req_bus.valid))) begin
            next_item             = annexb_bytes.pop_front();
            req_bus.valid         <= 1'b1;
            req_bus.byte_in       <= next_item.value;
            req_bus.end_of_packet <= next_item.eop;
            gap_left              <= calm ? 0 : $urandom_range(0, 3);
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Result receiver: random stalls per beat, one long hold-off
   // ------------------------------------------------------------------------
   int  stall_left;
   bit  long_hold_done;
   int  stall_draw;

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready  <= 1'b0;
         stall_left     <= 0;
         long_hold_done <= 1'b0;
      end else if (stall_left != 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left    <= stall_left - 1;
      end else if (!long_hold_done && beats_checked >= HOLD_AFTER) begin
         long_hold_done <= 1'b1;
         rsp_bus.ready  <= 1'b0;
         stall_left     <= LONG_HOLD;
      end else if (rsp_bus.ready && rsp_bus.valid) begin
         stall_draw = calm ? 0 : $urandom_range(0, 3);
         if (stall_draw != 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left    <= stall_draw - 1;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // ------------------------------------------------------------------------
   // Monitor: predict on accepted bytes, check accepted result beats
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : beat_monitor
      nal_beat_type got;
      nal_beat_type want;
      if (reset) begin
         clear_state();
         expected_beats.delete();
         bytes_taken   <= 0;
         beats_checked <= 0;
         results_idle  <= 1'b1;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            predict_byte(req_bus.byte_in, req_bus.end_of_packet);
            bytes_taken <= bytes_taken + 1;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.kind         = rsp_bus.kind;
            got.data_byte    = rsp_bus.data_byte;
            got.first_of_nal = rsp_bus.first_of_nal;
            got.nal_length   = rsp_bus.nal_length;
            got.packet_done  = rsp_bus.packet_done;
            got.last_of_step = rsp_bus.last_of_step;
            beats_checked <= beats_checked + 1;
            if (expected_beats.size() == 0) begin
               flag_error($sformatf("unexpected beat kind=%b data=%h len=%h",
                                    got.kind, got.data_byte, got.nal_length));
            end else begin
               want = expected_beats.pop_front();
               if (got.kind !== want.kind || got.data_byte !== want.data_byte ||
                   got.first_of_nal !== want.first_of_nal ||
                   got.nal_length !== want.nal_length ||
                   got.packet_done !== want.packet_done ||
                   got.last_of_step !== want.last_of_step) begin
                  flag_error($sformatf({"mismatch exp kind=%b data=%h first=%b len=%h ",
                                        "done=%b last=%b got kind=%b data=%h first=%b ",
                                        "len=%h done=%b last=%b"},
                                       want.kind, want.data_byte, want.first_of_nal,
                                       want.nal_length, want.packet_done, want.last_of_step,
                                       got.kind, got.data_byte, got.first_of_nal,
                                       got.nal_length, got.packet_done, got.last_of_step));
               end
            end
         end
         results_idle <= (expected_beats.size() == 0);
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus and end of run
   // ------------------------------------------------------------------------
   initial begin : stimulus
      int nals;
      int len;
      int k;

      // Garbage, 3-byte start, released zeros, closing zeros with 4-byte
      // start, empty NAL, and end of packet with two held zeros
      pkt_bytes = '{8'hFF, 8'h00, 8'h00, 8'h01, 8'h65, 8'h00, 8'h00, 8'h02,
                    8'h00, 8'h00, 8'h00, 8'h01, 8'hFF, 8'h00, 8'h00, 8'h01,
                    8'h00, 8'h00, 8'h01, 8'h80, 8'h00, 8'h00};
      commit_packet(1'b1);
      // Packet without a start code
      pkt_bytes = '{8'h5A};
      commit_packet(1'b0);
      // End of packet on the start code itself
      pkt_bytes = '{8'h00, 8'h00, 8'h01};
      commit_packet(1'b1);

      // Mostly well-formed packets with random content, some noise
      while (annexb_bytes.size() < RANDOM_BYTES) begin
         if ($urandom_range(0, 99) < 85) begin
            repeat ($urandom_range(0, 2))
               pkt_bytes = {pkt_bytes, BYTE_W'($urandom_range(2, 255))};
            nals = $urandom_range(1, 4);
            for (k = 0; k < nals; k++) begin
               if ($urandom_range(0, 1) != 0) pkt_bytes = {pkt_bytes, 8'h00};
               pkt_bytes = {pkt_bytes, 8'h00, 8'h00, 8'h01};
               len = $urandom_range(0, 12);
               repeat (len) pkt_bytes = {pkt_bytes, pick_byte()};
            end
         end else begin
            repeat ($urandom_range(1, 6)) pkt_bytes = {pkt_bytes, pick_byte()};
         end
         commit_packet($urandom_range(0, 11) == 0);
      end
      total_items = annexb_bytes.size();

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Drain: all bytes taken, all results seen, then let the pipe settle
      while (bytes_taken != total_items) @(posedge clock);
      while (!results_idle) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      @(negedge clock);
      if (expected_beats.size() != 0)
         flag_error($sformatf("%0d expected beats never arrived", expected_beats.size()));

      if (mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
